FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CRPE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crpe check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CRPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crpe check failed");

`endif

FILE: hw/rtl/crpe_pkg.sv
// Package: constants, codes and types of the Catmull-Rom point evaluator.
`default_nettype none
package crpe_pkg;
    localparam int MAX_POINTS_DEF  = 1024;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam int SLOT_W  = 10;
    localparam int COORD_W = 32;
    localparam int POS_W   = 17;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = 12;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic CFG_CLOSED = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    typedef logic [3*COORD_W-1:0] point_t;

    typedef struct packed {
        logic adv;
        logic wr;
    } ctl_t;
endpackage
`default_nettype wire

FILE: hw/rtl/crpe_in_if.sv
// Input channel: write or evaluate transactions.
`default_nettype none
interface crpe_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [crpe_pkg::SLOT_W-1:0]       slot;
    logic signed [crpe_pkg::COORD_W-1:0] coord_x;
    logic signed [crpe_pkg::COORD_W-1:0] coord_y;
    logic signed [crpe_pkg::COORD_W-1:0] coord_z;
    logic [crpe_pkg::POS_W-1:0]        position;

    modport source (output valid, opcode, slot, coord_x, coord_y, coord_z, position,
                    input ready);
    modport sink (input valid, opcode, slot, coord_x, coord_y, coord_z, position,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/crpe_out_if.sv
// Output channel: evaluated points.
`default_nettype none
interface crpe_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [crpe_pkg::COORD_W-1:0] point_x;
    logic signed [crpe_pkg::COORD_W-1:0] point_y;
    logic signed [crpe_pkg::COORD_W-1:0] point_z;
    logic [crpe_pkg::STAT_W-1:0]         status;

    modport source (output valid, point_x, point_y, point_z, status, input ready);
    modport sink (input valid, point_x, point_y, point_z, status, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/crpe_fetch.sv
// Config registers, neighbor addressing and four replicated point memories.
`default_nettype none
module crpe_fetch #(
    parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire crpe_pkg::ctl_t              ctl,
    input  wire                              cfg_we,
    input  wire                              cfg_index,
    input  wire [crpe_pkg::COUNT_W-1:0]      cfg_data,
    input  wire [crpe_pkg::SLOT_W-1:0]       slot,
    input  wire crpe_pkg::point_t            wr_point,
    output crpe_pkg::point_t                 pts [4],
    output logic                             oor
);
    import crpe_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);

    logic               closed_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] pc0;
    logic [IDX_W-1:0]   cnt, s, s1, s2, s2w, last;
    logic [IDX_W-1:0]   idx [4];
    logic               oor_next;

    point_t mem0 [MAX_POINTS];
    point_t mem1 [MAX_POINTS];
    point_t mem2 [MAX_POINTS];
    point_t mem3 [MAX_POINTS];
    point_t rd_reg [4];
    logic   oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_reg <= 1'b0;
            count_reg  <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLOSED: closed_reg <= cfg_data[0];
                CFG_COUNT:  count_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        pc0  = (count_reg == '0) ? COUNT_W'(1) : count_reg;
        cnt  = (32'(pc0) > MAX_POINTS) ? IDX_W'(MAX_POINTS) : IDX_W'(pc0);
        last = cnt - IDX_W'(1);
        s    = IDX_W'(slot);
        s1   = s + IDX_W'(1);
        s2   = s + IDX_W'(2);
        s2w  = s2 - cnt;
        oor_next = (s >= cnt);
        idx[1] = s;
        if (closed_reg)
        begin
            idx[0] = (s == '0) ? last : s - IDX_W'(1);
            idx[2] = (s1 >= cnt) ? '0 : s1;
            idx[3] = (s2 >= cnt) ? ((s2w >= cnt) ? '0 : s2w) : s2;
        end
        else
        begin
            idx[0] = (s == '0) ? '0 : s - IDX_W'(1);
            idx[2] = (s1 > last) ? last : s1;
            idx[3] = (s2 > last) ? last : s2;
        end
    end

    // write and read can share an edge: one transaction per cycle while the pipeline advances
    always_ff @(posedge clk)
    begin
        if (ctl.wr && (32'(slot) < MAX_POINTS))
        begin
            mem0[ADDR_W'(slot)] <= wr_point;
            mem1[ADDR_W'(slot)] <= wr_point;
            mem2[ADDR_W'(slot)] <= wr_point;
            mem3[ADDR_W'(slot)] <= wr_point;
        end
        if (ctl.adv)
        begin
            rd_reg[0] <= mem0[ADDR_W'(idx[0])];
            rd_reg[1] <= mem1[ADDR_W'(idx[1])];
            rd_reg[2] <= mem2[ADDR_W'(idx[2])];
            rd_reg[3] <= mem3[ADDR_W'(idx[3])];
            oor_reg   <= oor_next;
        end
    end

    assign pts = rd_reg;
    assign oor = oor_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/crpe_coef.sv
// Basis coefficient pipeline: t^2, t^3 and the four weights over three stages.
`default_nettype none
module crpe_coef #(
    parameter int T_FRAC_BITS = crpe_pkg::T_FRAC_BITS_DEF,
    parameter int CW          = T_FRAC_BITS + 5
) (
    input  wire                         clk,
    input  wire crpe_pkg::ctl_t         ctl,
    input  wire [crpe_pkg::POS_W-1:0]   position,
    output logic signed [CW-1:0]        coef [4]
);
    import crpe_pkg::*;

    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = 2 * TW;
    localparam logic [TW-1:0] ONE  = TW'(1) << T_FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

    logic [TW-1:0] tc;
    logic [TW-1:0] t1_reg, t2a_reg, t2b_reg;
    logic [PW-1:0] sq_reg, cu_reg, sq_rnd, cu_rnd;
    logic [TW-1:0] t2, t3;
    logic signed [CW-1:0] st, st2, st3, one2;
    logic signed [CW-1:0] coef_reg [4];

    assign tc = (32'(position) > 32'(ONE)) ? ONE : TW'(position);

    always_comb
    begin
        sq_rnd = sq_reg + HALF;
        t2     = TW'(sq_rnd >> T_FRAC_BITS);
        cu_rnd = cu_reg + HALF;
        t3     = TW'(cu_rnd >> T_FRAC_BITS);
        st     = CW'(t2a_reg);
        st2    = CW'(t2b_reg);
        st3    = CW'(t3);
        one2   = CW'(ONE) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            t1_reg   <= tc;
            sq_reg   <= PW'(tc) * PW'(tc);
            t2a_reg  <= t1_reg;
            t2b_reg  <= t2;
            cu_reg   <= PW'(t2) * PW'(t1_reg);
            coef_reg[0] <= (st2 <<< 1) - st3 - st;
            coef_reg[1] <= CW'((st3 * 3) - (st2 * 5) + one2);
            coef_reg[2] <= CW'((st2 <<< 2) - (st3 * 3) + st);
            coef_reg[3] <= st3 - st2;
        end
    end

    // note: t2a_reg carries t aligned with cu_reg
    assign coef = coef_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/crpe_blend.sv
// Weighted sum per axis, rounding, saturation and the output register.
`default_nettype none
module crpe_blend #(
    parameter int T_FRAC_BITS = crpe_pkg::T_FRAC_BITS_DEF,
    parameter int CW          = T_FRAC_BITS + 5
) (
    input  wire                                 clk,
    input  wire crpe_pkg::ctl_t                 ctl,
    input  wire crpe_pkg::point_t               pts [4],
    input  wire                                 oor,
    input  wire signed [CW-1:0]                 coef [4],
    output logic signed [crpe_pkg::COORD_W-1:0] point_x,
    output logic signed [crpe_pkg::COORD_W-1:0] point_y,
    output logic signed [crpe_pkg::COORD_W-1:0] point_z,
    output logic [crpe_pkg::STAT_W-1:0]         status
);
    import crpe_pkg::*;

    localparam int PW = COORD_W + CW;
    localparam int SW = PW + 3;
    localparam int RW = SW - T_FRAC_BITS - 1;
    localparam logic signed [SW-1:0] RND = SW'(1) << T_FRAC_BITS;

    point_t pa_reg [4];
    point_t pb_reg [4];
    logic   oor2_reg, oor3_reg, oor4_reg, oor5_reg;
    logic signed [PW-1:0] prod_reg [3][4];
    logic signed [PW:0]   pair_reg [3][2];
    logic signed [SW-1:0] sum [3];
    logic signed [RW-1:0] r [3];
    logic signed [COORD_W-1:0] res [3];
    logic [2:0] sat;
    logic signed [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [STAT_W-1:0] st_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = SW'(pair_reg[a][0]) + SW'(pair_reg[a][1]) + RND;
            r[a]   = RW'(sum[a] >>> (T_FRAC_BITS + 1));
            sat[a] = (r[a] > RW'(32'sh7FFF_FFFF)) || (r[a] < -(RW'(32'sh7FFF_FFFF)) - 1);
            if (r[a] > RW'(32'sh7FFF_FFFF))
                res[a] = 32'sh7FFF_FFFF;
            else if (sat[a])
                res[a] = 32'sh8000_0000;
            else
                res[a] = COORD_W'(r[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            pa_reg   <= pts;
            pb_reg   <= pa_reg;
            oor2_reg <= oor;
            oor3_reg <= oor2_reg;
            oor4_reg <= oor3_reg;
            oor5_reg <= oor4_reg;
            for (int a = 0; a < 3; a++)
            begin
                for (int k = 0; k < 4; k++)
                    prod_reg[a][k] <= PW'($signed(pb_reg[k][a*COORD_W +: COORD_W])) * PW'(coef[k]);
                pair_reg[a][0] <= (PW+1)'(prod_reg[a][0]) + (PW+1)'(prod_reg[a][1]);
                pair_reg[a][1] <= (PW+1)'(prod_reg[a][2]) + (PW+1)'(prod_reg[a][3]);
            end
            if (oor5_reg)
            begin
                x_reg  <= '0;
                y_reg  <= '0;
                z_reg  <= '0;
                st_reg <= ST_RANGE;
            end
            else
            begin
                x_reg  <= res[0];
                y_reg  <= res[1];
                z_reg  <= res[2];
                st_reg <= (|sat) ? ST_SAT : ST_OK;
            end
        end
    end

    assign point_x = x_reg;
    assign point_y = y_reg;
    assign point_z = z_reg;
    assign status  = st_reg;
endmodule
`default_nettype wire

FILE: hw/rtl/catmull_rom_point_evaluator_unit.sv
// Catmull-Rom point evaluator: takes one transaction per cycle, write or evaluate,
// and returns an evaluated point for each accepted evaluate at a sustained rate of
// one result per cycle, both while the output is not stalled. Four replicated copies
// of the point memory give the four neighbor reads each cycle; the t^2 and t^3
// multiplies, the coefficient step, the per-axis products, two adder levels and the
// round/saturate step make up the stages. A stall on the output freezes the whole
// pipeline. The memory is not cleared after reset; unwritten points read as garbage.
`default_nettype none
module catmull_rom_point_evaluator_unit #(
    parameter int MAX_POINTS  = crpe_pkg::MAX_POINTS_DEF,
    parameter int T_FRAC_BITS = crpe_pkg::T_FRAC_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    crpe_in_if.sink                     req,
    crpe_out_if.source                  rsp,
    input  wire                         cfg_we,
    input  wire                         cfg_index,
    input  wire [crpe_pkg::COUNT_W-1:0] cfg_data
);
    import crpe_pkg::*;

    localparam int CW = T_FRAC_BITS + 5;

    ctl_t   ctl;
    logic   adv;
    point_t wr_point;
    point_t pts [4];
    logic   oor;
    logic signed [CW-1:0] coef [4];
    logic [5:0] v_reg, v_next;

    assign adv      = !v_reg[5] || rsp.ready;
    assign ctl.adv  = adv;
    assign ctl.wr   = req.valid && adv && (req.opcode == OP_WRITE);
    assign req.ready = adv;
    assign wr_point = {req.coord_z, req.coord_y, req.coord_x};

    assign v_next = {v_reg[4:0], req.valid && (req.opcode == OP_EVAL)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    crpe_fetch #(.MAX_POINTS(MAX_POINTS)) u_fetch (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .slot(req.slot), .wr_point(wr_point), .pts(pts), .oor(oor)
    );

    crpe_coef #(.T_FRAC_BITS(T_FRAC_BITS), .CW(CW)) u_coef (
        .clk(clk), .ctl(ctl), .position(req.position), .coef(coef)
    );

    crpe_blend #(.T_FRAC_BITS(T_FRAC_BITS), .CW(CW)) u_blend (
        .clk(clk), .ctl(ctl), .pts(pts), .oor(oor), .coef(coef),
        .point_x(rsp.point_x), .point_y(rsp.point_y), .point_z(rsp.point_z),
        .status(rsp.status)
    );

    assign rsp.valid = v_reg[5];
endmodule
`default_nettype wire

FILE: hw/rtl/crpe_checker.sv
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module crpe_checker (
    input wire                         clk,
    input wire                         rst_n,
    input wire                         in_ready,
    input wire                         out_valid,
    input wire                         out_ready,
    input wire [crpe_pkg::COORD_W-1:0] out_x,
    input wire [crpe_pkg::COORD_W-1:0] out_y,
    input wire [crpe_pkg::COORD_W-1:0] out_z,
    input wire [crpe_pkg::STAT_W-1:0]  out_status
);
    import crpe_pkg::*;

    `CRPE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_status))
    `CRPE_ASSERT_NOW(a_range_zero, out_valid && out_status == ST_RANGE, out_x == '0 && out_y == '0 && out_z == '0)
    `CRPE_ASSERT_NOW(a_status_code, out_valid, out_status == ST_OK || out_status == ST_RANGE || out_status == ST_SAT)
    `CRPE_ASSERT_NOW(a_ready_flow, 1'b1, in_ready == (!out_valid || out_ready))
endmodule

bind catmull_rom_point_evaluator_unit crpe_checker u_crpe_checker (
    .clk(clk), .rst_n(rst_n), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .out_x(rsp.point_x), .out_y(rsp.point_y), .out_z(rsp.point_z),
    .out_status(rsp.status)
);
`default_nettype wire

FILE: tb/catmull_rom_point_evaluator_unit_tb.sv
// Self-checking testbench for the Catmull-Rom point evaluator unit.
`default_nettype none
module catmull_rom_point_evaluator_unit_tb;
    import crpe_pkg::*;

    localparam int NPTS       = 1024;
    localparam int ONE_T      = 65536;
    localparam int DRAIN_WAIT = 10;
    localparam int STALL_CAP  = 20000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [STAT_W-1:0]         st;
    } curve_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = CFG_CLOSED;
    logic [COUNT_W-1:0] cfg_data = '0;

    crpe_in_if  req_if ();
    crpe_out_if rsp_if ();

    catmull_rom_point_evaluator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // shadow of the block state
    int   ctrl_pts [0:NPTS-1][0:2];
    bit   loop_mode = 1'b0;
    int   count_reg = 1;
    curve_point_t pending_points [$];

    int   errors = 0;
    bit   idle_on = 1'b1;
    int   hold_req = 0;
    int   stall_left = 0;
    int   quiet_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int live_count();
        if (count_reg == 0)
            return 1;
        if (count_reg > NPTS)
            return NPTS;
        return count_reg;
    endfunction

    function automatic int neighbor_idx(input int s, input int k, input int cnt);
        int i;
        i = s + k;
        if (loop_mode)
            return (i + cnt) % cnt;
        if (i < 0)
            return 0;
        if (i > cnt - 1)
            return cnt - 1;
        return i;
    endfunction

    // Expected curve point for one evaluate transaction.
    function automatic curve_point_t eval_curve(input int s, input logic [POS_W-1:0] pos);
        curve_point_t res;
        longint t, t2, t3, sum, r;
        longint c [4];
        int idx [4];
        int cnt;
        cnt = live_count();
        res.x = '0;
        res.y = '0;
        res.z = '0;
        res.st = ST_OK;
        if (s >= cnt)
        begin
            res.st = ST_RANGE;
            return res;
        end
        t = (pos > ONE_T) ? ONE_T : pos;
        t2 = (t * t + 32768) >> 16;
        t3 = (t2 * t + 32768) >> 16;
        c[0] = 2 * t2 - t3 - t;
        c[1] = 3 * t3 - 5 * t2 + 2 * ONE_T;
        c[2] = 4 * t2 - 3 * t3 + t;
        c[3] = t3 - t2;
        for (int k = 0; k < 4; k++)
            idx[k] = neighbor_idx(s, k - 1, cnt);
        for (int a = 0; a < 3; a++)
        begin
            sum = 0;
            for (int k = 0; k < 4; k++)
                sum += longint'(ctrl_pts[idx[k]][a]) * c[k];
            // floor((sum + 2^16) / 2^17)
            r = (sum + 65536) >>> 17;
            if (r > 64'sd2147483647)
            begin
                r = 64'sd2147483647;
                res.st = ST_SAT;
            end
            if (r < -64'sd2147483648)
            begin
                r = -64'sd2147483648;
                res.st = ST_SAT;
            end
            case (a)
                0: res.x = r[31:0];
                1: res.y = r[31:0];
                default: res.z = r[31:0];
            endcase
        end
        return res;
    endfunction

    task automatic send_item(input logic op, input int s, input int x, input int y,
                             input int z, input int pos);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.slot     <= s[SLOT_W-1:0];
        req_if.coord_x  <= x;
        req_if.coord_y  <= y;
        req_if.coord_z  <= z;
        req_if.position <= pos[POS_W-1:0];
        do
            @(posedge clk);
        while (!req_if.ready);
        if (op == OP_WRITE)
        begin
            ctrl_pts[s][0] = x;
            ctrl_pts[s][1] = y;
            ctrl_pts[s][2] = z;
        end
        else
            pending_points.push_back(eval_curve(s, pos[POS_W-1:0]));
    endtask

    task automatic stop_sending();
        req_if.valid <= 1'b0;
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 2) == 0)
            return int'($urandom());
        return int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    endfunction

    function automatic int rand_pos();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return ONE_T;
            2: return $urandom_range(ONE_T + 1, 131071);
            default: return $urandom_range(0, ONE_T);
        endcase
    endfunction

    task automatic write_point(input int s, input int x, input int y, input int z);
        send_item(OP_WRITE, s, x, y, z, $urandom_range(0, 131071));
    endtask

    task automatic eval_segment(input int s, input int pos);
        send_item(OP_EVAL, s, int'($urandom()), int'($urandom()), int'($urandom()), pos);
    endtask

    // Registers change only once the pipeline has emptied.
    task automatic wait_drained();
        stop_sending();
        wait (pending_points.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[COUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CLOSED)
            loop_mode = val[0];
        else
            count_reg = val[COUNT_W-1:0];
    endtask

    task automatic fill_points(input int n, input bit wide);
        for (int i = 0; i < n; i++)
            if (wide)
                write_point(i, rand_coord(), rand_coord(), rand_coord());
            else
                write_point(i, int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                            int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                            int'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
    endtask

    task automatic test_directed();
        // reset state: open mode, one point
        write_point(0, 32'h0001_0000, -32'sh0002_0000, 32'h7fff_ffff);
        eval_segment(0, 0);
        eval_segment(0, ONE_T);
        eval_segment(0, 131071);
        eval_segment(1, 32768);
        eval_segment(1023, 0);
        write_reg(CFG_COUNT, 4);
        write_point(0, 32'h7fff_ffff, 32'h8000_0000, 0);
        write_point(1, 32'h7fff_ffff, 32'h8000_0000, 32'h0003_0000);
        write_point(2, 32'h7fff_ffff, 32'h8000_0000, -32'sh0001_8000);
        write_point(3, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        write_point(1023, 32'h5555_aaaa, 32'haaaa_5555, 32'h0f0f_f0f0);
        for (int s = 0; s < 4; s++)
            eval_segment(s, (s == 3) ? ONE_T : 32768 * (s % 3));
        eval_segment(4, 100);
        write_reg(CFG_CLOSED, 1);
        eval_segment(0, 12345);
        eval_segment(3, 54321);
        write_reg(CFG_COUNT, 0);
        eval_segment(0, 40000);
        eval_segment(1, 40000);
        write_reg(CFG_CLOSED, 0);
        stop_sending();
    endtask

    task automatic run_phase(input int cnt, input int n_items);
        int s;
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_CLOSED, $urandom_range(0, 1));
        fill_points(live_count(), 1'b1);
        for (int i = 0; i < n_items; i++)
            if ($urandom_range(0, 4) == 0)
            begin
                s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NPTS - 1)
                                                : $urandom_range(0, live_count() - 1);
                write_point(s, rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NPTS - 1)
                                                : $urandom_range(0, live_count() - 1);
                eval_segment(s, rand_pos());
            end
        stop_sending();
    endtask

    task automatic test_random_phases();
        run_phase(2, 60);
        run_phase(3, 60);
        for (int p = 0; p < 5; p++)
            run_phase($urandom_range(1, 16), 60);
    endtask

    task automatic test_full_count();
        write_reg(CFG_COUNT, NPTS);
        fill_points(NPTS, 1'b0);
        for (int i = 0; i < 60; i++)
            eval_segment($urandom_range(0, NPTS - 1), rand_pos());
        eval_segment(0, 20000);
        eval_segment(NPTS - 1, 20000);
        write_reg(CFG_CLOSED, 1);
        eval_segment(0, 20000);
        eval_segment(NPTS - 1, 20000);
        write_reg(CFG_COUNT, 2047);
        for (int i = 0; i < 40; i++)
            eval_segment($urandom_range(0, NPTS - 1), rand_pos());
        stop_sending();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_COUNT, 8);
        write_reg(CFG_CLOSED, 0);
        hold_req = 300;
        for (int i = 0; i < 60; i++)
            eval_segment($urandom_range(0, 7), rand_pos());
        stop_sending();
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        run_phase($urandom_range(4, 12), 200);
    endtask

    // response side: stalls and result checks
    always @(posedge clk)
    begin
        curve_point_t exp_pt;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (pending_points.size() == 0)
                    report_mismatch("result with nothing pending");
                else
                begin
                    exp_pt = pending_points.pop_front();
                    if (rsp_if.point_x !== exp_pt.x)
                        report_mismatch($sformatf("point_x %h, want %h",
                                                  rsp_if.point_x, exp_pt.x));
                    if (rsp_if.point_y !== exp_pt.y)
                        report_mismatch($sformatf("point_y %h, want %h",
                                                  rsp_if.point_y, exp_pt.y));
                    if (rsp_if.point_z !== exp_pt.z)
                        report_mismatch($sformatf("point_z %h, want %h",
                                                  rsp_if.point_z, exp_pt.z));
                    if (rsp_if.status !== exp_pt.st)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  rsp_if.status, exp_pt.st));
                end
            end
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 15);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // watchdog on transactions
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_WRITE;
        req_if.slot     = '0;
        req_if.coord_x  = '0;
        req_if.coord_y  = '0;
        req_if.coord_z  = '0;
        req_if.position = '0;
        rsp_if.ready    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_full_count();
        test_backpressure();
        test_no_idle();
        stop_sending();
        wait (pending_points.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
